>>> rtl/dual_serial_controller_registers_macros.svh
// Assertion macros shared by the serial controller register file RTL.
`ifndef DUAL_SERIAL_CONTROLLER_REGISTERS_MACROS_SVH
`define DUAL_SERIAL_CONTROLLER_REGISTERS_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define DSCR_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define DSCR_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/dscr_pkg.sv
// Types, codes and constants for the dual-channel serial controller register file.
package dscr_pkg;

    // Default receive queue depth per channel
    localparam int RX_FIFO_DEPTH_DEF = 16;

    // Request codes
    typedef enum logic [2:0] {
        REQ_CTRL_WR  = 3'd0,
        REQ_STAT_RD  = 3'd1,
        REQ_DATA_RD  = 3'd2,
        REQ_DATA_WR  = 3'd3,
        REQ_RX_BYTE  = 3'd4,
        REQ_IRQ_POLL = 3'd5
    } t_req;

    // Command field of WR0, bits 5:3
    typedef enum logic [2:0] {
        CMD_RST_EXT  = 3'd2,
        CMD_CH_RESET = 3'd3,
        CMD_RST_TX   = 3'd5,
        CMD_ERR_RST  = 3'd6,
        CMD_EOI      = 3'd7
    } t_cmd;

    // Register pointer values
    localparam logic [2:0] REG_0 = 3'd0;
    localparam logic [2:0] REG_1 = 3'd1;
    localparam logic [2:0] REG_2 = 3'd2;

    // Interrupt slots in priority order
    localparam int PRI_RXA   = 0;
    localparam int PRI_TXA   = 1;
    localparam int PRI_RXB   = 2;
    localparam int PRI_TXB   = 3;
    localparam int PRI_EXTA  = 4;
    localparam int PRI_EXTB  = 5;
    localparam int PRI_COUNT = 6;

    // Vector low bits placed by a poll
    localparam logic [2:0] VEC_RXA  = 3'b110;
    localparam logic [2:0] VEC_TXA  = 3'b100;
    localparam logic [2:0] VEC_RXB  = 3'b010;
    localparam logic [2:0] VEC_TXB  = 3'b000;
    localparam logic [2:0] VEC_NONE = 3'b111;

    // Fixed bits of RR0 (tx empty, DCD, CTS) and the constant RR1
    localparam logic [7:0] RR0_A_FIXED = 8'h2C;
    localparam logic [7:0] RR0_B_FIXED = 8'h04;
    localparam logic [7:0] RR1_VALUE   = 8'h01;

    localparam int BYTE_W = 8;

    // Result of one request before the receive memory data is merged
    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic              rd_ram;
        logic              irq;
        logic              txv;
        logic [BYTE_W-1:0] txb;
        logic              under;
        logic              drop;
    } t_step_res;

    // Result as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              irq_line;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              rx_underflow;
        logic              rx_dropped;
    } t_res_out;

endpackage

>>> rtl/dscr_if.sv
// Request and result channel interfaces of the serial controller register file.
interface dscr_req_if;
    import dscr_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic              channel;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output req_type, output channel, output data_byte,
                    input ready);
    modport sink   (input valid, input req_type, input channel, input data_byte,
                    output ready);
endinterface

interface dscr_res_if;
    import dscr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              irq_line;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              rx_underflow;
    logic              rx_dropped;

    modport source (output valid, output read_data, output irq_line, output tx_valid,
                    output tx_byte, output rx_underflow, output rx_dropped,
                    input ready);
    modport sink   (input valid, input read_data, input irq_line, input tx_valid,
                    input tx_byte, input rx_underflow, input rx_dropped,
                    output ready);
endinterface

>>> rtl/dscr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dscr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: hold data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dscr_ctrl.sv
// Register state, receive queue pointers and interrupt chain of both channels.
`include "dual_serial_controller_registers_macros.svh"

module dscr_ctrl #(
    parameter int RX_FIFO_DEPTH = dscr_pkg::RX_FIFO_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [2:0]                 i_req_type,
    input  logic                       i_channel,
    input  logic [dscr_pkg::BYTE_W-1:0] i_data_byte,
    output dscr_pkg::t_step_res        o_res,
    output logic                       o_ram_we,
    output logic [((RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1):0] o_ram_waddr,
    output logic [dscr_pkg::BYTE_W-1:0] o_ram_wdata,
    output logic                       o_ram_re,
    output logic [((RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1):0] o_ram_raddr
);
    import dscr_pkg::*;

    localparam int IW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(RX_FIFO_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(RX_FIFO_DEPTH);
    localparam logic [IW-1:0] LAST = IW'(RX_FIFO_DEPTH - 1);

    // Register pointers and the interrupt enables that matter
    logic [2:0]           r_ptr    [2];
    logic [2:0]           n_ptr    [2];
    logic [1:0]           r_tx_ie, n_tx_ie;
    logic [1:0]           r_rx_ie, n_rx_ie;
    logic [4:0]           r_wr2b,  n_wr2b;
    // Variable RR0 bits: tx underrun per channel, pending on channel A
    logic [1:0]           r_und,   n_und;
    logic                 r_pend,  n_pend;
    logic [BYTE_W-1:0]    r_vector, n_vector;
    logic [PRI_COUNT-1:0] r_req_f, n_req_f;
    logic [PRI_COUNT-1:0] r_acc_f, n_acc_f;
    // Receive queue pointers
    logic [IW-1:0]        r_head [2];
    logic [IW-1:0]        n_head [2];
    logic [IW-1:0]        r_tail [2];
    logic [IW-1:0]        n_tail [2];
    logic [CW-1:0]        r_cnt  [2];
    logic [CW-1:0]        n_cnt  [2];

    logic                 ch;
    logic [BYTE_W-1:0]    d;
    logic [2:0]           ptr;
    logic [PRI_COUNT-1:0] req_low;
    logic [PRI_COUNT-1:0] acc_low;
    logic [BYTE_W-1:0]    rr0;
    int                   rx_slot;
    int                   tx_slot;
    int                   ext_slot;
    t_step_res            res;

    assign ch  = i_channel;
    assign d   = i_data_byte;
    assign ptr = r_ptr[ch];

    // Highest-priority requested and accepted slots
    assign req_low = r_req_f & (~r_req_f + PRI_COUNT'(1));
    assign acc_low = r_acc_f & (~r_acc_f + PRI_COUNT'(1));

    assign rx_slot  = ch ? PRI_RXB  : PRI_RXA;
    assign tx_slot  = ch ? PRI_TXB  : PRI_TXA;
    assign ext_slot = ch ? PRI_EXTB : PRI_EXTA;

    // RR0 of the addressed channel
    always_comb begin
        if (ch) begin
            rr0 = RR0_B_FIXED | {1'b0, r_und[1], 5'b0, (r_cnt[1] != '0)};
        end else begin
            rr0 = RR0_A_FIXED | {1'b0, r_und[0], 4'b0, r_pend, (r_cnt[0] != '0)};
        end
    end

    // Work out the effect of one request
    always_comb begin
        n_ptr    = r_ptr;
        n_tx_ie  = r_tx_ie;
        n_rx_ie  = r_rx_ie;
        n_wr2b   = r_wr2b;
        n_und    = r_und;
        n_pend   = r_pend;
        n_vector = r_vector;
        n_req_f  = r_req_f;
        n_acc_f  = r_acc_f;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        res      = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = {ch, r_head[ch]};
        o_ram_wdata = d;
        o_ram_re    = 1'b0;
        o_ram_raddr = {ch, r_tail[ch]};

        if (i_accept) begin
            case (t_req'(i_req_type))
                REQ_CTRL_WR: begin
                    n_ptr[ch] = '0;
                    case (ptr)
                        REG_0: n_ptr[ch] = d[2:0];
                        REG_1: begin
                            n_tx_ie[ch] = d[1];
                            n_rx_ie[ch] = |d[4:3];
                        end
                        REG_2: begin
                            if (ch) begin
                                n_wr2b = d[7:3];
                            end
                        end
                        default: ;
                    endcase
                    if (ptr == REG_0) begin
                        case (t_cmd'(d[5:3]))
                            CMD_RST_EXT:  n_req_f[ext_slot] = 1'b0;
                            CMD_CH_RESET: begin
                                n_ptr[ch]   = '0;
                                n_tx_ie[ch] = 1'b0;
                                n_rx_ie[ch] = 1'b0;
                                if (ch) begin
                                    n_wr2b = '0;
                                end
                                n_head[ch] = '0;
                                n_tail[ch] = '0;
                                n_cnt[ch]  = '0;
                                n_req_f[rx_slot]  = 1'b0;
                                n_req_f[tx_slot]  = 1'b0;
                                n_req_f[ext_slot] = 1'b0;
                                n_acc_f[rx_slot]  = 1'b0;
                                n_acc_f[tx_slot]  = 1'b0;
                                n_acc_f[ext_slot] = 1'b0;
                                n_und[ch] = 1'b1;
                            end
                            CMD_RST_TX:   n_req_f[tx_slot] = 1'b0;
                            // Error bits of RR1 never get set, so nothing to clear
                            CMD_ERR_RST:  ;
                            CMD_EOI: begin
                                if (!ch) begin
                                    n_acc_f = r_acc_f & ~acc_low;
                                end
                            end
                            default: ;
                        endcase
                        if (d[7:6] == 2'b11) begin
                            n_und[ch] = 1'b0;
                        end
                    end
                end

                REQ_STAT_RD: begin
                    n_ptr[ch] = '0;
                    if (ch && (ptr == REG_2)) begin
                        n_acc_f = r_acc_f | req_low;
                    end
                    case (ptr)
                        REG_0:   res.rd = rr0;
                        REG_1:   res.rd = RR1_VALUE;
                        REG_2:   res.rd = ch ? r_vector : '0;
                        default: res.rd = '0;
                    endcase
                end

                REQ_DATA_RD: begin
                    if (r_cnt[ch] == '0) begin
                        res.under = 1'b1;
                    end else begin
                        o_ram_re   = 1'b1;
                        res.rd_ram = 1'b1;
                        n_tail[ch] = (r_tail[ch] == LAST) ? '0 : r_tail[ch] + IW'(1);
                        n_cnt[ch]  = r_cnt[ch] - CW'(1);
                    end
                    if (n_cnt[ch] == '0) begin
                        n_req_f[rx_slot] = 1'b0;
                    end else if (r_rx_ie[ch]) begin
                        n_req_f[rx_slot] = 1'b1;
                    end
                end

                REQ_DATA_WR: begin
                    if (!ch) begin
                        res.txv = 1'b1;
                        res.txb = d;
                    end
                    if (r_tx_ie[ch]) begin
                        n_req_f[tx_slot] = 1'b1;
                    end
                end

                REQ_RX_BYTE: begin
                    if (r_cnt[ch] == FULL) begin
                        res.drop = 1'b1;
                    end else begin
                        o_ram_we   = 1'b1;
                        n_head[ch] = (r_head[ch] == LAST) ? '0 : r_head[ch] + IW'(1);
                        n_cnt[ch]  = r_cnt[ch] + CW'(1);
                    end
                    if (n_cnt[ch] == '0) begin
                        n_req_f[rx_slot] = 1'b0;
                    end else if (r_rx_ie[ch]) begin
                        n_req_f[rx_slot] = 1'b1;
                    end
                end

                REQ_IRQ_POLL: begin
                    if (|r_acc_f) begin
                        res.irq = 1'b1;
                    end else if (|req_low[PRI_TXB:PRI_RXA]) begin
                        if (req_low[PRI_RXA]) begin
                            n_vector = {r_wr2b, VEC_RXA};
                        end else if (req_low[PRI_TXA]) begin
                            n_vector = {r_wr2b, VEC_TXA};
                        end else if (req_low[PRI_RXB]) begin
                            n_vector = {r_wr2b, VEC_RXB};
                        end else begin
                            n_vector = {r_wr2b, VEC_TXB};
                        end
                        n_pend  = 1'b1;
                        res.irq = 1'b1;
                    end else begin
                        n_vector = {r_wr2b, VEC_NONE};
                        n_pend   = 1'b0;
                    end
                end

                default: ;
            endcase
        end
    end

    assign o_res = res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '{default: '0};
            r_tx_ie  <= '0;
            r_rx_ie  <= '0;
            r_wr2b   <= '0;
            r_und    <= 2'b11;
            r_pend   <= 1'b0;
            r_vector <= '0;
            r_req_f  <= '0;
            r_acc_f  <= '0;
            r_head   <= '{default: '0};
            r_tail   <= '{default: '0};
            r_cnt    <= '{default: '0};
        end else begin
            r_ptr    <= n_ptr;
            r_tx_ie  <= n_tx_ie;
            r_rx_ie  <= n_rx_ie;
            r_wr2b   <= n_wr2b;
            r_und    <= n_und;
            r_pend   <= n_pend;
            r_vector <= n_vector;
            r_req_f  <= n_req_f;
            r_acc_f  <= n_acc_f;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
        end
    end

    `DSCR_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_cnt[0] <= FULL) && (r_cnt[1] <= FULL), "receive fill count beyond depth")
    `DSCR_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, i_accept && (i_req_type == REQ_RX_BYTE) && !i_channel && (r_cnt[0] != FULL), r_cnt[0] == $past(r_cnt[0]) + CW'(1), "accepted byte not counted")
    `DSCR_ASSERT_NEXT(a_poll_hold, i_clk, i_rst_n, i_accept && (i_req_type == REQ_IRQ_POLL) && (|r_acc_f), (r_vector == $past(r_vector)) && (r_pend == $past(r_pend)), "poll changed state while in service")

endmodule

>>> rtl/dscr_out.sv
// Two-entry result pipeline: memory read stage then output register.
`include "dual_serial_controller_registers_macros.svh"

module dscr_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  dscr_pkg::t_step_res         i_res,
    input  logic [dscr_pkg::BYTE_W-1:0] i_ram_q,
    output logic                        o_in_ready,
    output logic                        o_valid,
    input  logic                        i_out_ready,
    output dscr_pkg::t_res_out          o_data
);
    import dscr_pkg::*;

    logic      r_s1_valid, n_s1_valid;
    logic      r_o_valid,  n_o_valid;
    t_step_res r_s1;
    t_res_out  r_o;
    t_res_out  n_o;
    logic      s1_move;

    // Advance the read stage when the output register is free or being taken
    assign s1_move    = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;

    // Merge memory data into the result
    always_comb begin
        n_o.read_data    = r_s1.rd_ram ? i_ram_q : r_s1.rd;
        n_o.irq_line     = r_s1.irq;
        n_o.tx_valid     = r_s1.txv;
        n_o.tx_byte      = r_s1.txb;
        n_o.rx_underflow = r_s1.under;
        n_o.rx_dropped   = r_s1.drop;

        n_s1_valid = i_push ? 1'b1 : (s1_move ? 1'b0 : r_s1_valid);
        n_o_valid  = s1_move ? 1'b1 : (i_out_ready ? 1'b0 : r_o_valid);
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1 <= i_res;
        end
        if (s1_move) begin
            r_o <= n_o;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o;

    `DSCR_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !o_in_ready, r_s1_valid && r_o_valid, "input stalled with a free stage")
    `DSCR_ASSERT_NEXT(a_s1_drain, i_clk, i_rst_n, s1_move && !i_push, !r_s1_valid, "read stage kept a moved result")
    `DSCR_ASSERT_NEXT(a_ram_take, i_clk, i_rst_n, s1_move && r_s1.rd_ram, r_o.read_data == $past(i_ram_q), "received byte lost on the way out")

endmodule

>>> rtl/dual_serial_controller_registers.sv
// Top level of the dual-channel serial controller register file.
//
//   Port    Dir   Handshake      Carries
//   i_req   in    valid/ready    req_type, channel, data_byte
//   o_res   out   valid/ready    read_data, irq_line, tx_valid, tx_byte,
//                                rx_underflow, rx_dropped
//
// One request is taken per cycle unless the output stalls; the result passes
// the read stage (registered receive memory read), then the output register.
// Reset is synchronous and active low; it clears all control state and empties
// both receive queues (memory contents are left as they are). i_req.ready is
// held low while reset is asserted.
// A stalled output holds one result and one more in the read stage before
// i_req.ready drops.
module dual_serial_controller_registers #(
    parameter int RX_FIFO_DEPTH = dscr_pkg::RX_FIFO_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dscr_req_if.sink     i_req,
    dscr_res_if.source   o_res
);
    import dscr_pkg::*;

    localparam int IW = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int RAM_DEPTH = 2 << IW;

    logic              accept;
    logic              in_ready;
    t_step_res         step_res;
    t_res_out          out_data;
    logic              ram_we;
    logic [IW:0]       ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IW:0]       ram_raddr;
    logic [BYTE_W-1:0] ram_q;

    // Refuse transfers while reset is asserted
    assign i_req.ready = in_ready && i_rst_n;
    assign accept      = i_req.valid && i_req.ready;

    // Register state and interrupt chain
    dscr_ctrl #(
        .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req.req_type),
        .i_channel   (i_req.channel),
        .i_data_byte (i_req.data_byte),
        .o_res       (step_res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    // Receive bytes of both channels, channel in the top address bit
    dscr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Result pipeline
    dscr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_res       (step_res),
        .i_ram_q     (ram_q),
        .o_in_ready  (in_ready),
        .o_valid     (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_data      (out_data)
    );

    assign o_res.read_data    = out_data.read_data;
    assign o_res.irq_line     = out_data.irq_line;
    assign o_res.tx_valid     = out_data.tx_valid;
    assign o_res.tx_byte      = out_data.tx_byte;
    assign o_res.rx_underflow = out_data.rx_underflow;
    assign o_res.rx_dropped   = out_data.rx_dropped;

endmodule
